// ===== hw/rtl/dpgm_pkg.sv =====
// Shared types, constants and the fixed pattern table for the dash pattern gun mask.
// No dependencies; every other file of the block imports this package.
package dpgm_pkg;

    // Field widths
    localparam int POS_W    = 32;
    localparam int IDX_W    = 4;
    localparam int MASK_W   = 6;
    localparam int LINE_W   = 13;
    localparam int CYC_W    = 14;
    localparam int RECIP_W  = 32;
    // Reciprocal scale: recip = floor(2^RECIP_SH / cycle), quotient = product >> RECIP_SH
    localparam int RECIP_SH = 42;
    localparam int PROD_W   = POS_W + RECIP_W;
    localparam int QUO_W    = PROD_W - RECIP_SH;
    // Remainder estimate stays below twice the longest cycle
    localparam int REM_W    = 15;

    localparam int GUN_COUNT     = 6;
    localparam int PATTERN_COUNT = 15;

    localparam logic [MASK_W-1:0] GUN_ALLOWED =
        (GUN_COUNT >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << GUN_COUNT) - 1);

    // Gun bits, one per gun; dual patterns use GUN_1 and GUN_3
    localparam logic [MASK_W-1:0] GUN_1  = 6'h01;
    localparam logic [MASK_W-1:0] GUN_2  = 6'h02;
    localparam logic [MASK_W-1:0] GUN_3  = 6'h04;
    localparam logic [MASK_W-1:0] GUN_4  = 6'h08;
    localparam logic [MASK_W-1:0] GUN_5  = 6'h10;
    localparam logic [MASK_W-1:0] GUN_6  = 6'h20;
    localparam logic [MASK_W-1:0] GUN_NONE = 6'h00;

    // Line lengths and cycle lengths (line + gap) in mm
    localparam logic [LINE_W-1:0] LINE_0    = 13'd0;
    localparam logic [LINE_W-1:0] LINE_1000 = 13'd1000;
    localparam logic [LINE_W-1:0] LINE_2000 = 13'd2000;
    localparam logic [LINE_W-1:0] LINE_4000 = 13'd4000;
    localparam logic [CYC_W-1:0]  CYC_0     = 14'd0;
    localparam logic [CYC_W-1:0]  CYC_2000  = 14'd2000;
    localparam logic [CYC_W-1:0]  CYC_4000  = 14'd4000;
    localparam logic [CYC_W-1:0]  CYC_6000  = 14'd6000;
    localparam logic [CYC_W-1:0]  CYC_12000 = 14'd12000;

    // floor(2^42 / cycle)
    localparam logic [RECIP_W-1:0] RECIP_0     = 32'd0;
    localparam logic [RECIP_W-1:0] RECIP_2000  = 32'd2199023255;
    localparam logic [RECIP_W-1:0] RECIP_4000  = 32'd1099511627;
    localparam logic [RECIP_W-1:0] RECIP_6000  = 32'd733007751;
    localparam logic [RECIP_W-1:0] RECIP_12000 = 32'd366503875;

    typedef enum logic [1:0] {
        KIND_CONT  = 2'd0,
        KIND_DASH  = 2'd1,
        KIND_DMIX  = 2'd2,
        KIND_DCONT = 2'd3
    } t_kind;

    // One table entry, with the cycle length and its reciprocal precomputed
    typedef struct packed {
        t_kind               kind;
        logic [LINE_W-1:0]   line;
        logic [CYC_W-1:0]    cyc;
        logic [RECIP_W-1:0]  recip;
        logic [MASK_W-1:0]   guns;
    } t_entry;

    // Per-beat pattern data that rides the pipeline
    typedef struct packed {
        t_kind               kind;
        logic [LINE_W-1:0]   line;
        logic [CYC_W-1:0]    cyc;
        logic [MASK_W-1:0]   guns;
    } t_pat;

    // After lookup
    typedef struct packed {
        t_pat                pat;
        logic [RECIP_W-1:0]  recip;
        logic [POS_W-1:0]    pos;
    } t_lk;

    // After the modulo stages
    typedef struct packed {
        t_pat                pat;
        logic [REM_W-1:0]    pos_lo;
        logic [REM_W-1:0]    qc_lo;
    } t_mr;

    function automatic t_entry pat_entry(input logic [IDX_W-1:0] idx);
        t_entry e;
        case (idx)
            4'd0:    e = '{KIND_DASH,  LINE_4000, CYC_12000, RECIP_12000, GUN_2};
            4'd1:    e = '{KIND_DASH,  LINE_2000, CYC_6000,  RECIP_6000,  GUN_2};
            4'd2:    e = '{KIND_DASH,  LINE_2000, CYC_4000,  RECIP_4000,  GUN_2};
            4'd3:    e = '{KIND_DASH,  LINE_1000, CYC_2000,  RECIP_2000,  GUN_2};
            4'd4:    e = '{KIND_DASH,  LINE_1000, CYC_2000,  RECIP_2000,  GUN_4};
            4'd5:    e = '{KIND_CONT,  LINE_0,    CYC_0,     RECIP_0,     GUN_2};
            4'd6:    e = '{KIND_CONT,  LINE_0,    CYC_0,     RECIP_0,     GUN_4};
            4'd7:    e = '{KIND_DMIX,  LINE_4000, CYC_6000,  RECIP_6000,  GUN_1 | GUN_3};
            4'd8:    e = '{KIND_DMIX,  LINE_1000, CYC_2000,  RECIP_2000,  GUN_1 | GUN_3};
            4'd9:    e = '{KIND_DCONT, LINE_0,    CYC_0,     RECIP_0,     GUN_1 | GUN_3};
            4'd10:   e = '{KIND_DASH,  LINE_4000, CYC_6000,  RECIP_6000,  GUN_5};
            4'd11:   e = '{KIND_DASH,  LINE_1000, CYC_2000,  RECIP_2000,  GUN_6};
            4'd12:   e = '{KIND_CONT,  LINE_0,    CYC_0,     RECIP_0,     GUN_6};
            4'd13:   e = '{KIND_DASH,  LINE_1000, CYC_2000,  RECIP_2000,  GUN_5};
            4'd14:   e = '{KIND_CONT,  LINE_0,    CYC_0,     RECIP_0,     GUN_5};
            default: e = '{KIND_CONT,  LINE_0,    CYC_0,     RECIP_0,     GUN_NONE};
        endcase
        return e;
    endfunction

endpackage

// ===== hw/rtl/dpgm_if.sv =====
// Valid/ready channel interfaces for the position input and the gun mask result.
// Depends on dpgm_pkg for field widths.
interface dpgm_in_if;
    import dpgm_pkg::*;
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   position;
    logic [IDX_W-1:0]   pattern_index;
    modport source (output valid, output position, output pattern_index, input ready);
    modport sink   (input valid, input position, input pattern_index, output ready);
endinterface

interface dpgm_out_if;
    import dpgm_pkg::*;
    logic               valid;
    logic               ready;
    logic [MASK_W-1:0]  gun_mask;
    modport source (output valid, output gun_mask, input ready);
    modport sink   (input valid, input gun_mask, output ready);
endinterface

// ===== hw/rtl/dpgm_lookup.sv =====
// Stage 1: clamp the pattern index and register the table entry with the position.
// Depends on dpgm_pkg for the pattern table and stage types.
module dpgm_lookup (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [dpgm_pkg::POS_W-1:0] i_position,
    input  logic [dpgm_pkg::IDX_W-1:0] i_pattern_index,
    output logic                       o_valid,
    input  logic                       i_ready,
    output dpgm_pkg::t_lk              o_stage
);
    import dpgm_pkg::*;

    logic             r_vld;
    t_lk              r_stage;
    t_lk              n_stage;
    logic [IDX_W-1:0] idx;
    t_entry           ent;

    // Out-of-range index falls back to entry zero
    always_comb begin
        idx = ({1'b0, i_pattern_index} >= (IDX_W + 1)'(PATTERN_COUNT)) ? '0 : i_pattern_index;
        ent = pat_entry(idx);
        n_stage.pat.kind = ent.kind;
        n_stage.pat.line = ent.line;
        n_stage.pat.cyc  = ent.cyc;
        n_stage.pat.guns = ent.guns & GUN_ALLOWED;
        n_stage.recip    = ent.recip;
        n_stage.pos      = i_position;
    end

    assign o_ready = !r_vld || i_ready;

    // Advance when the stage is empty or its beat moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_vld;
    assign o_stage = r_stage;
endmodule

// ===== hw/rtl/dpgm_modulo.sv =====
// Stages 2 and 3: quotient estimate by reciprocal multiply, then quotient times cycle.
// Depends on dpgm_pkg for stage types and the reciprocal scale.
module dpgm_modulo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  dpgm_pkg::t_lk i_stage,
    output logic          o_valid,
    input  logic          i_ready,
    output dpgm_pkg::t_mr o_stage
);
    import dpgm_pkg::*;

    logic              r_vld_q;
    t_pat              r_pat_q;
    logic [REM_W-1:0]  r_pos_q;
    logic [QUO_W-1:0]  r_quo;
    logic              r_vld_m;
    t_mr               r_stage;
    logic [PROD_W-1:0] prod;
    logic [QUO_W+CYC_W-1:0] qc;
    logic              adv_q;
    logic              adv_m;

    assign adv_m   = !r_vld_m || i_ready;
    assign adv_q   = !r_vld_q || adv_m;
    assign o_ready = adv_q;

    // Quotient estimate: equals the true quotient or one less
    assign prod = PROD_W'(i_stage.pos) * PROD_W'(i_stage.recip);
    assign qc   = (QUO_W + CYC_W)'(r_quo) * (QUO_W + CYC_W)'(r_pat_q.cyc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_q <= 1'b0;
            r_vld_m <= 1'b0;
        end else begin
            if (adv_q) begin
                r_vld_q <= i_valid;
            end
            if (adv_m) begin
                r_vld_m <= r_vld_q;
            end
        end
    end

    // Hold the quotient beat
    always_ff @(posedge i_clk) begin
        if (adv_q && i_valid) begin
            r_pat_q <= i_stage.pat;
            r_pos_q <= i_stage.pos[REM_W-1:0];
            r_quo   <= prod[PROD_W-1:RECIP_SH];
        end
    end

    // Only the low bits of quotient times cycle matter for the remainder
    always_ff @(posedge i_clk) begin
        if (adv_m && r_vld_q) begin
            r_stage.pat    <= r_pat_q;
            r_stage.pos_lo <= r_pos_q;
            r_stage.qc_lo  <= qc[REM_W-1:0];
        end
    end

    assign o_valid = r_vld_m;
    assign o_stage = r_stage;
endmodule

// ===== hw/rtl/dpgm_mask.sv =====
// Stage 4: finish the remainder, test line versus gap and register the gun mask.
// Depends on dpgm_pkg for stage types, pattern kinds and gun constants.
module dpgm_mask (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_reversed,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  dpgm_pkg::t_mr               i_stage,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [dpgm_pkg::MASK_W-1:0] o_gun_mask
);
    import dpgm_pkg::*;

    logic              r_vld;
    logic [MASK_W-1:0] r_mask;
    logic [MASK_W-1:0] n_mask;
    logic [REM_W-1:0]  rem_est;
    logic [REM_W-1:0]  rem;
    logic              on;

    // Correct the remainder estimate once, then compare with the line length
    always_comb begin
        rem_est = i_stage.pos_lo - i_stage.qc_lo;
        rem     = (rem_est >= REM_W'(i_stage.pat.cyc)) ?
                  rem_est - REM_W'(i_stage.pat.cyc) : rem_est;
        on      = rem < REM_W'(i_stage.pat.line);
    end

    always_comb begin
        case (i_stage.pat.kind)
            KIND_CONT:  n_mask = i_stage.pat.guns;
            KIND_DASH:  n_mask = on ? i_stage.pat.guns : GUN_NONE;
            KIND_DMIX: begin
                if (!i_reversed) begin
                    n_mask = GUN_1 | (on ? GUN_3 : GUN_NONE);
                end else begin
                    n_mask = GUN_3 | (on ? GUN_1 : GUN_NONE);
                end
            end
            KIND_DCONT: n_mask = GUN_1 | GUN_3;
            default:    n_mask = GUN_NONE;
        endcase
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mask <= n_mask;
        end
    end

    assign o_valid    = r_vld;
    assign o_gun_mask = r_mask;
endmodule

// ===== hw/rtl/dash_pattern_gun_mask.sv =====
// Dash pattern gun mask: maps a travelled distance and a pattern index to six gun enables.
// Depends on dpgm_pkg, dpgm_if, dpgm_lookup, dpgm_modulo and dpgm_mask.
//
// Usage:
//   i_item carries one beat of position (mm) and pattern_index; o_result returns one
//   gun_mask beat per input beat, in order. Both channels use valid/ready.
//   i_cfg_we / i_cfg_wdata write the reversed bit; write it only while the block is idle.
// Pipeline: four register stages (table lookup, reciprocal multiply, quotient-times-cycle
//   multiply, mask) carry each beat; the two multiplies set the stage depth.
// Throughput: one beat per cycle while o_result is ready; each stage takes a new beat
//   whenever it is empty or its beat moves on, so bubbles are squeezed out.
// Stall: when o_result.ready is low the output register holds its beat and the stages
//   behind it fill up; i_item.ready drops once all four are full. No beat is lost or
//   repeated.
// Reset: synchronous, active low. All stage valid bits clear and reversed returns to 0.
//   The pattern table is constant, so no fill or clear pass is needed.
module dash_pattern_gun_mask (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    dpgm_in_if.sink    i_item,
    dpgm_out_if.source o_result
);
    import dpgm_pkg::*;

    logic r_reversed;
    logic lk_valid;
    logic lk_ready;
    t_lk  lk_stage;
    logic mr_valid;
    logic mr_ready;
    t_mr  mr_stage;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reversed <= 1'b0;
        end else if (i_cfg_we) begin
            r_reversed <= i_cfg_wdata;
        end
    end

    dpgm_lookup u_lookup (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_item.valid),
        .o_ready         (i_item.ready),
        .i_position      (i_item.position),
        .i_pattern_index (i_item.pattern_index),
        .o_valid         (lk_valid),
        .i_ready         (lk_ready),
        .o_stage         (lk_stage)
    );

    dpgm_modulo u_modulo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lk_valid),
        .o_ready (lk_ready),
        .i_stage (lk_stage),
        .o_valid (mr_valid),
        .i_ready (mr_ready),
        .o_stage (mr_stage)
    );

    dpgm_mask u_mask (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_reversed (r_reversed),
        .i_valid    (mr_valid),
        .o_ready    (mr_ready),
        .i_stage    (mr_stage),
        .o_valid    (o_result.valid),
        .i_ready    (o_result.ready),
        .o_gun_mask (o_result.gun_mask)
    );

    // No result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_result.valid)
        else $error("result valid right after reset");

    // With the receiver always ready, an accepted beat must come out on o_result without stalling
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && o_result.ready) ##1 o_result.ready
            ##1 o_result.ready ##1 o_result.ready |=> o_result.valid)
        else $error("accepted beat did not reach the output in time");

    // Only allowed guns or the dual guns ever fire
    a_mask_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((o_result.gun_mask & ~(GUN_ALLOWED | GUN_1 | GUN_3)) == GUN_NONE))
        else $error("gun mask drives a gun outside the allowed set");
endmodule

// ===== tb/sv/tb_dash_pattern_gun_mask.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dash_pattern_gun_mask: directed and random position beats,
// random idling on both channels, a long result hold-off, and reversed-bit phases.
// Depends on dpgm_pkg, dpgm_if and the block's RTL.
module tb_dash_pattern_gun_mask;
    import dpgm_pkg::*;

    localparam int LATENCY     = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS_PER_PHASE = 150;
    localparam int DIRECTED_COUNT = 23;

    // Directed beats: table extremes, line/gap boundaries, every pattern and the
    // out-of-range index
    localparam logic [POS_W-1:0] DIR_POS [DIRECTED_COUNT] = '{
        32'd0, 32'd3999, 32'd4000, 32'd11999, 32'd12000, 32'hFFFF_FFFF,
        32'd1999, 32'd2000, 32'd999, 32'd1000, 32'hFFFF_FFFF, 32'd0,
        32'd3999, 32'd4000, 32'd1000, 32'd2999, 32'd12345, 32'd5999,
        32'd2999, 32'd7, 32'd3000, 32'd1, 32'd3999
    };
    localparam logic [IDX_W-1:0] DIR_IDX [DIRECTED_COUNT] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
        4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd10,
        4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    // Expected gun masks in beat order, with a private copy of the reversed bit
    class gun_mask_scoreboard;
        logic [MASK_W-1:0] pending_masks[$];
        bit                reversed;
        int unsigned       mismatches;

        function new();
            reversed   = 1'b0;
            mismatches = 0;
        endfunction

        // Marking patterns: kind, line length, gap length and assigned guns
        static function void pattern_of(input logic [IDX_W-1:0] idx, output t_kind kind,
                                        output int unsigned line_mm,
                                        output int unsigned gap_mm,
                                        output logic [MASK_W-1:0] guns);
            kind = KIND_CONT; line_mm = 0; gap_mm = 0; guns = GUN_NONE;
            case (idx)
                4'd0: begin kind = KIND_DASH; line_mm = 4000; gap_mm = 8000; guns = GUN_2; end
                4'd1: begin kind = KIND_DASH; line_mm = 2000; gap_mm = 4000; guns = GUN_2; end
                4'd2: begin kind = KIND_DASH; line_mm = 2000; gap_mm = 2000; guns = GUN_2; end
                4'd3: begin kind = KIND_DASH; line_mm = 1000; gap_mm = 1000; guns = GUN_2; end
                4'd4: begin kind = KIND_DASH; line_mm = 1000; gap_mm = 1000; guns = GUN_4; end
                4'd5: guns = GUN_2;
                4'd6: guns = GUN_4;
                4'd7: begin
                    kind = KIND_DMIX; line_mm = 4000; gap_mm = 2000; guns = GUN_1 | GUN_3;
                end
                4'd8: begin
                    kind = KIND_DMIX; line_mm = 1000; gap_mm = 1000; guns = GUN_1 | GUN_3;
                end
                4'd9: begin kind = KIND_DCONT; guns = GUN_1 | GUN_3; end
                4'd10: begin kind = KIND_DASH; line_mm = 4000; gap_mm = 2000; guns = GUN_5; end
                4'd11: begin kind = KIND_DASH; line_mm = 1000; gap_mm = 1000; guns = GUN_6; end
                4'd12: guns = GUN_6;
                4'd13: begin kind = KIND_DASH; line_mm = 1000; gap_mm = 1000; guns = GUN_5; end
                4'd14: guns = GUN_5;
                default: guns = GUN_NONE;
            endcase
        endfunction

        function logic [MASK_W-1:0] predict_gun_mask(input logic [POS_W-1:0] pos,
                                                     input logic [IDX_W-1:0] idx);
            t_kind             kind;
            int unsigned       line_mm;
            int unsigned       gap_mm;
            int unsigned       cycle_mm;
            logic [MASK_W-1:0] guns;
            logic [IDX_W-1:0]  sel;
            bit                painting;
            logic [MASK_W-1:0] mask;
            // Out-of-range index falls back to the first pattern
            sel = (int'(idx) >= PATTERN_COUNT) ? '0 : idx;
            pattern_of(sel, kind, line_mm, gap_mm, guns);
            cycle_mm = line_mm + gap_mm;
            // A zero cycle counts as always in the gap
            painting = (cycle_mm != 0) && ((pos % cycle_mm) < line_mm);
            case (kind)
                KIND_CONT: mask = guns & GUN_ALLOWED;
                KIND_DASH: mask = painting ? (guns & GUN_ALLOWED) : GUN_NONE;
                KIND_DMIX: begin
                    if (reversed)
                        mask = GUN_3 | (painting ? GUN_1 : GUN_NONE);
                    else
                        mask = GUN_1 | (painting ? GUN_3 : GUN_NONE);
                end
                default: mask = GUN_1 | GUN_3;
            endcase
            return mask;
        endfunction

        function void note_item(input logic [POS_W-1:0] pos, input logic [IDX_W-1:0] idx);
            pending_masks.push_back(predict_gun_mask(pos, idx));
        endfunction

        function void check_mask(input logic [MASK_W-1:0] actual);
            logic [MASK_W-1:0] want;
            if (pending_masks.size() == 0) begin
                $error("gun_mask: beat with nothing expected, expected none actual %h", actual);
                mismatches++;
            end else begin
                want = pending_masks.pop_front();
                if (actual !== want) begin
                    $error("gun_mask: expected %h actual %h", want, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    int unsigned cycle_count = 0;

    dpgm_in_if  item_ch ();
    dpgm_out_if result_ch ();

    gun_mask_scoreboard masks = new();

    dash_pattern_gun_mask dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    always #2 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Every fourth window of cycle_count picks no new random idling on either side
    function automatic bit calm_window();
        return ((cycle_count / 256) % 4) == 0;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm_window() || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Aim positions at line/gap edges, the top of the range, or anywhere
    function automatic logic [POS_W-1:0] random_position(input logic [IDX_W-1:0] idx);
        t_kind             kind;
        int unsigned       line_mm;
        int unsigned       gap_mm;
        logic [MASK_W-1:0] guns;
        int unsigned       roll;
        logic [POS_W-1:0]  base;
        gun_mask_scoreboard::pattern_of(idx, kind, line_mm, gap_mm, guns);
        roll = $urandom_range(0, 9);
        if (roll < 4 && (line_mm + gap_mm) != 0) begin
            base = $urandom_range(0, 350000) * (line_mm + gap_mm);
            base = base + (($urandom_range(0, 1) == 1) ? line_mm : 0);
            return base + $urandom_range(0, 4) - 2;
        end
        if (roll == 4) return 32'hFFFF_FFFF - $urandom_range(0, 20000);
        if (roll < 7) return $urandom_range(0, 30000);
        return $urandom;
    endfunction

    // Offer one beat and hold it until accepted
    task automatic send_item(input logic [POS_W-1:0] pos, input logic [IDX_W-1:0] idx);
        item_ch.valid         <= 1'b1;
        item_ch.position      <= pos;
        item_ch.pattern_index <= idx;
        do @(posedge i_clk); while (!item_ch.ready);
        masks.note_item(pos, idx);
    endtask

    task automatic idle_gap();
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected beat has come back
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (masks.pending_masks.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reversed(input bit value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        masks.reversed = value;
    endtask

    task automatic random_phase(input int unsigned count);
        logic [IDX_W-1:0] idx;
        repeat (count) begin
            idx = IDX_W'($urandom_range(0, 15));
            send_item(random_position(idx), idx);
            idle_gap();
        end
    endtask

    // Result side: check each beat, then pick ready for the next cycle
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned results_seen;
        int unsigned roll;
        bit          held_off;
        stall_left   = 0;
        results_seen = 0;
        held_off     = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        result_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (result_ch.valid && result_ch.ready) begin
                masks.check_mask(result_ch.gun_mask);
                results_seen++;
            end
            // Hold off once for a long stretch so the pipeline fills and stalls its input
            if (!held_off && results_seen == 100) begin
                held_off   = 1'b1;
                stall_left = 120;
            end else if (stall_left == 0 && !calm_window()) begin
                roll = $urandom_range(0, 99);
                if (roll >= 92)
                    stall_left = $urandom_range(8, 30);
                else if (roll >= 65)
                    stall_left = $urandom_range(1, 3);
            end
            if (stall_left != 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Reset, then directed beats, then random phases across reversed settings
    initial begin : stimulus
        item_ch.valid         <= 1'b0;
        item_ch.position      <= '0;
        item_ch.pattern_index <= '0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= 1'b0;
        i_rst_n               <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_item(DIR_POS[i], DIR_IDX[i]);
            idle_gap();
        end
        drain();

        // Swap steady and dashed guns on the dual-mixed patterns
        write_reversed(1'b1);
        send_item(32'd0, 4'd7);
        send_item(32'd4000, 4'd7);
        send_item(32'd999, 4'd8);
        send_item(32'd1000, 4'd8);
        random_phase(RANDOM_ITEMS_PER_PHASE);
        drain();

        write_reversed(1'b0);
        random_phase(RANDOM_ITEMS_PER_PHASE);
        drain();

        write_reversed(1'b1);
        random_phase(RANDOM_ITEMS_PER_PHASE);
        drain();

        if (masks.mismatches == 0 && masks.pending_masks.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
